>>> rtl/cdq_pkg.sv
// cdq_pkg: action and status codes and field widths of the circular deque
// no dependencies
package cdq_pkg;

  localparam int ACTION_BITS = 2;
  localparam int VALUE_BITS  = 32;
  localparam int OCC_BITS    = 5;
  localparam int STATUS_BITS = 2;
  localparam int IN_TDATA_BITS  = 40;
  localparam int OUT_TDATA_BITS = 40;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_PUSH_REAR  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

endpackage

>>> rtl/cdq_ram.sv
// cdq_ram: ring store of the circular deque, one write and one registered read port
// no dependencies
module cdq_ram #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WORD_BITS-1:0]     wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WORD_BITS-1:0]     rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/circular_deque.sv
// circular_deque: double-ended queue in a ring memory, pointer control and result register
// depends on cdq_pkg and cdq_ram
//
// The deque holds up to DEPTH words of WORD_BITS bits in a ring memory with a front
// index, a rear index and a word count. Each input transaction (in_tuser selects push
// rear, push front, pop front or pop rear) gives one result transaction carrying the
// status (ok, overflow on a full push, underflow on an empty pop), the popped word
// (zero unless a pop succeeded) and the occupancy after the action. A push or a
// refused pop is registered directly; a successful pop passes through S_POP for the
// registered ring read. Input is taken in the same cycle the previous result is
// delivered, but a result that waits on out_tready holds up the next input. The ring
// needs no clearing after reset: an entry is only read after a push wrote it.
module circular_deque #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cdq_pkg::IN_TDATA_BITS-1:0]   in_tdata,   // [31:0] data_value, rest zero
  input  logic [cdq_pkg::ACTION_BITS-1:0]     in_tuser,   // [1:0] action
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cdq_pkg::OUT_TDATA_BITS-1:0]  out_tdata,  // [31:0] popped_value,
                                                          // [36:32] occupancy, rest zero
  output logic [cdq_pkg::STATUS_BITS-1:0]     out_tuser   // [1:0] status
);

  import cdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {S_IDLE, S_POP} state_t;

  state_t                state_r;
  logic [AW-1:0]         head_r, head_nxt;
  logic [AW-1:0]         tail_r, tail_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  out_valid_r;
  logic [STATUS_BITS-1:0] out_status_r, status_nxt;
  logic [VALUE_BITS-1:0] out_value_r;
  logic [OCC_BITS-1:0]   out_occ_r;

  logic                  accept;
  logic                  is_empty;
  logic                  is_full;
  logic                  pop_ok;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [WORD_BITS-1:0]  mem_rdata;
  logic [63:0]           push_ext;
  logic [63:0]           pop_ext;
  logic [31:0]           occ_ext;
  action_t               act;

  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
  endfunction

  assign act       = action_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign is_empty  = (cnt_r == '0);
  assign is_full   = (cnt_r == CW'(DEPTH));

  assign push_ext  = {32'd0, in_tdata[VALUE_BITS-1:0]};
  assign mem_wdata = push_ext[WORD_BITS-1:0];
  assign pop_ext   = 64'(mem_rdata);
  assign occ_ext   = 32'(cnt_nxt);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    pop_ok     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_raddr  = head_r;
    unique case (act)
      ACT_PUSH_REAR, ACT_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          mem_we  = accept;
          cnt_nxt = cnt_r + 1'b1;
          if (is_empty) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            mem_waddr = '0;
          end else if (act == ACT_PUSH_REAR) begin
            tail_nxt  = idx_next(tail_r);
            mem_waddr = idx_next(tail_r);
          end else begin
            head_nxt  = idx_prev(head_r);
            mem_waddr = idx_prev(head_r);
          end
        end
      end
      default: begin
        if (is_empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          pop_ok  = 1'b1;
          cnt_nxt = cnt_r - 1'b1;
          if (act == ACT_POP_REAR) begin
            mem_raddr = tail_r;
          end
          // last word out returns both indices to the start of the ring
          if (cnt_r == CW'(1)) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else if (act == ACT_POP_FRONT) begin
            head_nxt = idx_next(head_r);
          end else begin
            tail_nxt = idx_prev(tail_r);
          end
        end
      end
    endcase
  end

  cdq_ram #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept && pop_ok),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (out_valid_r && out_tready) begin
            out_valid_r <= 1'b0;
          end
          if (accept) begin
            head_r       <= head_nxt;
            tail_r       <= tail_nxt;
            cnt_r        <= cnt_nxt;
            out_status_r <= status_nxt;
            out_value_r  <= '0;
            out_occ_r    <= occ_ext[OCC_BITS-1:0];
            // a successful pop waits in S_POP for the ring read data
            if (pop_ok) begin
              state_r <= S_POP;
            end else begin
              out_valid_r <= 1'b1;
            end
          end
        end
        S_POP: begin
          out_value_r <= pop_ext[VALUE_BITS-1:0];
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {(OUT_TDATA_BITS - VALUE_BITS - OCC_BITS)'(0), out_occ_r, out_value_r};

endmodule

>>> tb/sv/circular_deque_tb.sv
// circular_deque_tb: self-checking testbench for the circular deque
// depends on cdq_pkg and the circular_deque rtl; predicts every result transaction in place
`timescale 1ns / 100ps

module circular_deque_tb;
  import cdq_pkg::*;

  localparam int DEPTH         = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 6;
  localparam int STALL_LIMIT   = 3000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    status_t                 status;
    logic [VALUE_BITS-1:0]   popped;
    logic [OCC_BITS-1:0]     occupancy;
  } deque_result_t;

  typedef enum int {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_SPARSE,
    RX_PERIODIC
  } rx_pattern_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [IN_TDATA_BITS-1:0]   in_tdata = '0;   // [31:0] data_value, rest zero
  logic [ACTION_BITS-1:0]     in_tuser = '0;   // [1:0] action
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0]  out_tdata;       // [31:0] popped_value, [36:32] occupancy
  logic [STATUS_BITS-1:0]     out_tuser;       // [1:0] status

  circular_deque #(
    .DEPTH     (DEPTH),
    .WORD_BITS (VALUE_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // predicted deque contents
  logic [VALUE_BITS-1:0] deque_ring [DEPTH];
  int                    front_ptr = 0;
  int                    rear_ptr = 0;
  bit                    deque_empty = 1'b1;

  deque_result_t expected_results [$];
  int            mismatch_count = 0;

  // sender and receiver pacing
  int          tx_gap_max = 0;
  int          burst_left = 0;
  rx_pattern_t rx_pattern = RX_ALWAYS;
  int          hold_requests = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          rx_phase = 0;
  int          stall_cycles = 0;

  function automatic int words_stored();
    if (deque_empty) return 0;
    if (rear_ptr >= front_ptr) return rear_ptr - front_ptr + 1;
    return DEPTH - front_ptr + rear_ptr + 1;
  endfunction

  function automatic int ring_next(int i);
    return (i == DEPTH - 1) ? 0 : i + 1;
  endfunction

  function automatic int ring_prev(int i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  function automatic deque_result_t predict_deque_action(action_t act,
                                                         logic [VALUE_BITS-1:0] val);
    deque_result_t r;
    bit            full;
    full     = !deque_empty && ring_next(rear_ptr) == front_ptr;
    r.status = ST_OK;
    r.popped = '0;
    if (act == ACT_PUSH_REAR || act == ACT_PUSH_FRONT) begin
      if (full) begin
        r.status = ST_OVERFLOW;
      end else if (deque_empty) begin
        front_ptr     = 0;
        rear_ptr      = 0;
        deque_empty   = 1'b0;
        deque_ring[0] = val;
      end else if (act == ACT_PUSH_REAR) begin
        rear_ptr             = ring_next(rear_ptr);
        deque_ring[rear_ptr] = val;
      end else begin
        front_ptr             = ring_prev(front_ptr);
        deque_ring[front_ptr] = val;
      end
    end else begin
      if (deque_empty) begin
        r.status = ST_UNDERFLOW;
      end else if (front_ptr == rear_ptr) begin
        // last word leaves, both pointers go home
        r.popped    = deque_ring[front_ptr];
        front_ptr   = 0;
        rear_ptr    = 0;
        deque_empty = 1'b1;
      end else if (act == ACT_POP_FRONT) begin
        r.popped  = deque_ring[front_ptr];
        front_ptr = ring_next(front_ptr);
      end else begin
        r.popped = deque_ring[rear_ptr];
        rear_ptr = ring_prev(rear_ptr);
      end
    end
    r.occupancy = OCC_BITS'(words_stored());
    return r;
  endfunction

  function automatic logic [VALUE_BITS-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic action_t random_action(int push_pct);
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
    return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // valid stays high between back-to-back items; only a gap lowers it
  task automatic send_item(input action_t act, input logic [VALUE_BITS-1:0] val);
    int gap;
    if (tx_gap_max != 0) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, tx_gap_max);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(IN_TDATA_BITS-VALUE_BITS){1'b0}}, val};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_deque_action(act, val));
  endtask

  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_corners();
    rx_pattern <= RX_ALWAYS;
    tx_gap_max = 0;
    send_item(ACT_POP_FRONT, 32'h1234_5678);
    send_item(ACT_POP_REAR, 32'hffff_ffff);
    // push into empty, then take the last word off
    send_item(ACT_PUSH_REAR, 32'h7fff_ffff);
    send_item(ACT_POP_REAR, 32'h0);
    send_item(ACT_PUSH_FRONT, 32'h8000_0000);
    send_item(ACT_POP_FRONT, 32'h0);
    send_item(ACT_PUSH_FRONT, 32'hffff_ffff);
    send_item(ACT_PUSH_REAR, 32'h0000_0000);
    send_item(ACT_PUSH_FRONT, 32'h5555_5555);
    send_item(ACT_PUSH_REAR, 32'haaaa_aaaa);
    send_item(ACT_POP_FRONT, 32'h0);
    send_item(ACT_POP_REAR, 32'h0);
    send_item(ACT_POP_FRONT, 32'h0);
    send_item(ACT_POP_REAR, 32'h0);
    send_item(ACT_POP_FRONT, 32'h0);
    pause_until_drained();
  endtask

  task automatic test_fill_and_overflow(input int rounds);
    int n;
    for (int r = 0; r < rounds; r++) begin
      rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
      tx_gap_max = (r % 3 == 0) ? 0 : $urandom_range(2, 20);
      while (words_stored() < DEPTH)
        send_item($urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT, random_word());
      n = $urandom_range(1, 3);
      repeat (n)
        send_item($urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT, random_word());
      while (words_stored() > 0) begin
        // an occasional push keeps the pointers moving around the ring
        if ($urandom_range(0, 7) == 0)
          send_item($urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT, random_word());
        else
          send_item($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR, random_word());
      end
      n = $urandom_range(1, 2);
      repeat (n)
        send_item($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR, random_word());
    end
  endtask

  task automatic test_random_walk(input int items);
    int push_pct;
    push_pct = 50;
    for (int i = 0; i < items; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 3))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
        rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
        tx_gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);
      end
      send_item(random_action(push_pct), random_word());
    end
  endtask

  task automatic test_output_backpressure(input int items);
    rx_pattern <= RX_ALWAYS;
    tx_gap_max = 0;
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < items; i++)
      send_item(random_action(60), random_word());
    pause_until_drained();
  endtask

  task automatic test_full_rate(input int items);
    rx_pattern <= RX_ALWAYS;
    tx_gap_max = 0;
    for (int i = 0; i < items; i++)
      send_item(random_action(55), random_word());
  endtask

  // receiver: long hold on request, else a pattern of its own
  always @(posedge clk) begin
    rx_phase <= (rx_phase == 6) ? 0 : rx_phase + 1;
    if (hold_seen != hold_requests) begin
      hold_seen  <= hold_requests;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (rx_pattern)
        RX_ALWAYS:   out_tready <= 1'b1;
        RX_MOSTLY:   out_tready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE:   out_tready <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: out_tready <= (rx_phase < 3);
        default:     out_tready <= 1'b1;
      endcase
    end
  end

  deque_result_t oldest;
  status_t       got_status;
  logic [VALUE_BITS-1:0] got_popped;
  logic [OCC_BITS-1:0]   got_occ;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_status = status_t'(out_tuser);
      got_popped = out_tdata[VALUE_BITS-1:0];
      got_occ    = out_tdata[VALUE_BITS +: OCC_BITS];
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result transaction with nothing expected: st=%0d val=%h occ=%0d",
                               got_status, got_popped, got_occ));
      end else begin
        oldest = expected_results.pop_front();
        if (got_status !== oldest.status)
          note_failure($sformatf("status exp %0d got %0d", oldest.status, got_status));
        if (got_popped !== oldest.popped)
          note_failure($sformatf("popped_value exp %h got %h", oldest.popped, got_popped));
        if (got_occ !== oldest.occupancy)
          note_failure($sformatf("occupancy exp %0d got %0d", oldest.occupancy, got_occ));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("[circular_deque] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    test_fill_and_overflow(6);
    test_random_walk(600);
    test_output_backpressure(40);
    test_full_rate(150);
    pause_until_drained();
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0)
      $display("[circular_deque] OK");
    else
      $display("[circular_deque] ERROR");
    $finish;
  end

endmodule
